### design/spcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_pkg: shared constants and types for the sphere/node contact force block
// Widths below, but for the config index width, follow from the word width and the number of fraction bits.
// ----------------------------------------------------------------------------
package spcf_pkg;

    localparam int FRAC = 16;            // fraction bits of the fixed-point words
    localparam int W    = 32;            // signed position / velocity / force word
    localparam int UW   = W - 1;         // diameter and radius width
    localparam int DW   = W + 1;         // difference of two words
    localparam int SQW  = 2 * DW;        // sum of three squares
    localparam int RW   = SQW / 2;       // integer square root
    localparam int RMW  = RW + 4;        // square root partial remainder
    localparam int NW   = DW + FRAC;     // divider numerator |d| << FRAC
    localparam int QW   = FRAC + 1;      // unit vector component, up to 1.0
    localparam int FW   = 2 * W - FRAC;  // spring magnitude / damping term
    localparam int SMW  = FW + QW - FRAC;// spring component magnitude
    localparam int SUMW = SMW + 2;       // signed spring plus damping
    localparam int CIW  = 8;             // config register index width

    // Config register indexes
    localparam logic [CIW-1:0] REG_STIFFNESS = CIW'(0);
    localparam logic [CIW-1:0] REG_DAMPING   = CIW'(1);

    localparam logic [W-1:0] STIFF_RST = W'(1) << FRAC;

    // Saturation bounds
    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((longint'(1) << (W - 1)) - 1);
    localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(-(longint'(1) << (W - 1)));
    localparam logic [W-1:0] F_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] F_MIN = {1'b1, {(W - 1){1'b0}}};

    // Data carried alongside the square root
    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][DW-1:0]  mag;
        logic [2:0][W-1:0]   vel;
        logic [W-1:0]        wall;
    } t_sq_side;

    // Data carried alongside the divider
    typedef struct packed {
        logic                contact;
        logic                lzero;
        logic [W-1:0]        pen;
        logic [2:0]          neg;
        logic [2:0][W-1:0]   vel;
    } t_dv_side;

endpackage

### design/spcf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_sqrt: pipelined integer square root
// One result bit per stage (two radicand bits consumed), side data follows.
// ----------------------------------------------------------------------------
module spcf_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [spcf_pkg::SQW-1:0]    i_rad,
    input  spcf_pkg::t_sq_side          i_side,
    output logic                        o_valid,
    output logic [spcf_pkg::RW-1:0]     o_root,
    output spcf_pkg::t_sq_side          o_side
);

    logic                        r_vld  [spcf_pkg::RW];
    logic [spcf_pkg::RMW-1:0]    r_rem  [spcf_pkg::RW];
    logic [spcf_pkg::RW-1:0]     r_root [spcf_pkg::RW];
    logic [spcf_pkg::SQW-1:0]    r_rad  [spcf_pkg::RW];
    spcf_pkg::t_sq_side          r_side [spcf_pkg::RW];

    genvar k;
    for (k = 0; k < spcf_pkg::RW; k++) begin : g_stage
        logic                     a_vld;
        logic [spcf_pkg::RMW-1:0] a_rem;
        logic [spcf_pkg::RW-1:0]  a_root;
        logic [spcf_pkg::SQW-1:0] a_rad;
        spcf_pkg::t_sq_side       a_side;
        logic [spcf_pkg::RMW-1:0] cur;
        logic [spcf_pkg::RMW-1:0] trial;

        if (k == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_rad  = i_rad;
            assign a_side = i_side;
        end else begin : g_next
            assign a_vld  = r_vld[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
            assign a_rad  = r_rad[k-1];
            assign a_side = r_side[k-1];
        end

        // bring down two bits, try root*4+1
        assign cur   = {a_rem[spcf_pkg::RMW-3:0], a_rad[spcf_pkg::SQW-1 -: 2]};
        assign trial = spcf_pkg::RMW'({a_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= a_rad << 2;
                r_side[k] <= a_side;
                if (cur >= trial) begin
                    r_rem[k]  <= cur - trial;
                    r_root[k] <= {a_root[spcf_pkg::RW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= cur;
                    r_root[k] <= {a_root[spcf_pkg::RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[spcf_pkg::RW-1];
    assign o_root  = r_root[spcf_pkg::RW-1];
    assign o_side  = r_side[spcf_pkg::RW-1];

endmodule

### design/spcf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_div: pipelined restoring divider, three lanes sharing one divisor
// One quotient bit per stage; quotient assumed to fit QW bits.
// ----------------------------------------------------------------------------
module spcf_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [spcf_pkg::W-1:0]               i_div,
    input  logic [2:0][spcf_pkg::NW-1:0]         i_num,
    input  spcf_pkg::t_dv_side                   i_side,
    output logic                                 o_valid,
    output logic [2:0][spcf_pkg::QW-1:0]         o_quo,
    output spcf_pkg::t_dv_side                   o_side
);

    logic                              r_vld  [spcf_pkg::QW];
    logic [spcf_pkg::W-1:0]            r_div  [spcf_pkg::QW];
    logic [2:0][spcf_pkg::W-1:0]       r_rem  [spcf_pkg::QW];
    logic [2:0][spcf_pkg::QW-1:0]      r_low  [spcf_pkg::QW];
    logic [2:0][spcf_pkg::QW-1:0]      r_quo  [spcf_pkg::QW];
    spcf_pkg::t_dv_side                r_side [spcf_pkg::QW];

    genvar k;
    for (k = 0; k < spcf_pkg::QW; k++) begin : g_stage
        logic                           a_vld;
        logic [spcf_pkg::W-1:0]         a_div;
        logic [2:0][spcf_pkg::W-1:0]    a_rem;
        logic [2:0][spcf_pkg::QW-1:0]   a_low;
        logic [2:0][spcf_pkg::QW-1:0]   a_quo;
        spcf_pkg::t_dv_side             a_side;
        logic [2:0][spcf_pkg::W-1:0]    n_rem;
        logic [2:0][spcf_pkg::QW-1:0]   n_quo;

        if (k == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_div  = i_div;
            assign a_side = i_side;
            assign a_quo  = '0;
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign a_rem[j] = i_num[j][spcf_pkg::NW-1:spcf_pkg::QW];
                assign a_low[j] = i_num[j][spcf_pkg::QW-1:0];
            end
        end else begin : g_next
            assign a_vld  = r_vld[k-1];
            assign a_div  = r_div[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_low  = r_low[k-1];
            assign a_quo  = r_quo[k-1];
            assign a_side = r_side[k-1];
        end

        // trial subtract per lane
        always_comb begin
            logic [spcf_pkg::W:0] cur;
            for (int j = 0; j < 3; j++) begin
                cur = {a_rem[j], a_low[j][spcf_pkg::QW-1]};
                if (cur >= {1'b0, a_div}) begin
                    n_rem[j] = spcf_pkg::W'(cur - {1'b0, a_div});
                    n_quo[j] = {a_quo[j][spcf_pkg::QW-2:0], 1'b1};
                end else begin
                    n_rem[j] = cur[spcf_pkg::W-1:0];
                    n_quo[j] = {a_quo[j][spcf_pkg::QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[k]  <= a_div;
                r_side[k] <= a_side;
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                for (int j = 0; j < 3; j++) begin
                    r_low[k][j] <= a_low[j] << 1;
                end
            end
        end
    end

    assign o_valid = r_vld[spcf_pkg::QW-1];
    assign o_quo   = r_quo[spcf_pkg::QW-1];
    assign o_side  = r_side[spcf_pkg::QW-1];

endmodule

### design/sphere_node_penalty_contact_force_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_node_penalty_contact_force_top: spring/damper contact force
// Length of sphere-to-node vector, penetration test, spring force along the
// unit vector plus velocity damping, saturated to a signed word.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------
//  input     | i_valid / o_ready       | sphere, diameter, node, radius, velocity
//  result    | o_valid / i_ready       | in_contact, force xyz, saturated
//  config    | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One request per cycle sustained while i_ready keeps the output free; 3 front
//  stages, 33-stage square root, 1 compare stage, 17-stage divider, 3 multiply/sum
//  stages. Latency is dominated by the square root and divider pipelines.
//  Reset clears all valid bits and loads stiffness 1.0, damping 0.
//  When a result is held at the output, the whole pipeline freezes in place.
// ----------------------------------------------------------------------------
module sphere_node_penalty_contact_force_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [spcf_pkg::W-1:0] i_sphere_x,
    input  logic signed [spcf_pkg::W-1:0] i_sphere_y,
    input  logic signed [spcf_pkg::W-1:0] i_sphere_z,
    input  logic [spcf_pkg::UW-1:0]       i_sphere_diameter,
    input  logic signed [spcf_pkg::W-1:0] i_node_x,
    input  logic signed [spcf_pkg::W-1:0] i_node_y,
    input  logic signed [spcf_pkg::W-1:0] i_node_z,
    input  logic [spcf_pkg::UW-1:0]       i_node_radius,
    input  logic signed [spcf_pkg::W-1:0] i_vel_x,
    input  logic signed [spcf_pkg::W-1:0] i_vel_y,
    input  logic signed [spcf_pkg::W-1:0] i_vel_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_in_contact,
    output logic signed [spcf_pkg::W-1:0] o_force_x,
    output logic signed [spcf_pkg::W-1:0] o_force_y,
    output logic signed [spcf_pkg::W-1:0] o_force_z,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spcf_pkg::CIW-1:0]      i_cfg_index,
    input  logic [spcf_pkg::W-1:0]        i_cfg_data
);

    localparam int W = spcf_pkg::W;

    logic                              en;
    logic [W-1:0]                      r_stiff;
    logic [W-1:0]                      r_damp;

    // front stages
    logic                              r_s1_vld;
    logic [2:0][spcf_pkg::DW-1:0]      r_s1_d;
    logic [2:0][W-1:0]                 r_s1_vel;
    logic [W-1:0]                      r_s1_wall;
    logic                              r_s2_vld;
    logic [2:0][spcf_pkg::SQW-1:0]     r_s2_sq;
    spcf_pkg::t_sq_side                r_s2_side;
    spcf_pkg::t_sq_side                n_s2_side;
    logic [2:0][spcf_pkg::SQW-1:0]     n_s2_sq;
    logic                              r_s3_vld;
    logic [spcf_pkg::SQW-1:0]          r_s3_sum;
    spcf_pkg::t_sq_side                r_s3_side;

    // square root output, compare stage
    logic                              sq_vld;
    logic [spcf_pkg::RW-1:0]           sq_root;
    spcf_pkg::t_sq_side                sq_side;
    logic                              r_p1_vld;
    logic [W-1:0]                      r_p1_len;
    logic [2:0][spcf_pkg::NW-1:0]      r_p1_num;
    spcf_pkg::t_dv_side                r_p1_side;

    // divider output, back stages
    logic                              dv_vld;
    logic [2:0][spcf_pkg::QW-1:0]      dv_quo;
    spcf_pkg::t_dv_side                dv_side;
    logic                              r_q1_vld;
    logic                              r_q1_contact;
    logic [2:0]                        r_q1_neg;
    logic [2:0]                        r_q1_vneg;
    logic [spcf_pkg::FW-1:0]           r_q1_f;
    logic [2:0][spcf_pkg::FW-1:0]      r_q1_dm;
    logic [2:0][spcf_pkg::QW-1:0]      r_q1_u;
    logic                              r_q2_vld;
    logic                              r_q2_contact;
    logic [2:0]                        r_q2_neg;
    logic [2:0]                        r_q2_vneg;
    logic [2:0][spcf_pkg::SMW-1:0]     r_q2_sm;
    logic [2:0][spcf_pkg::FW-1:0]      r_q2_dm;

    // output register
    logic                              r_o_valid;
    logic                              r_o_contact;
    logic [2:0][W-1:0]                 r_o_force;
    logic                              r_o_sat;
    logic [2:0][W-1:0]                 n_o_force;
    logic                              n_o_sat;

    assign en          = !r_o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= spcf_pkg::STIFF_RST;
            r_damp  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                spcf_pkg::REG_STIFFNESS: r_stiff <= i_cfg_data;
                spcf_pkg::REG_DAMPING:   r_damp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_q1_vld  <= 1'b0;
            r_q2_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= i_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_p1_vld  <= sq_vld;
            r_q1_vld  <= dv_vld;
            r_q2_vld  <= r_q1_vld;
            r_o_valid <= r_q2_vld;
        end
    end

    // S1: differences and contact distance
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_d[0]  <= {i_sphere_x[W-1], i_sphere_x} - {i_node_x[W-1], i_node_x};
            r_s1_d[1]  <= {i_sphere_y[W-1], i_sphere_y} - {i_node_y[W-1], i_node_y};
            r_s1_d[2]  <= {i_sphere_z[W-1], i_sphere_z} - {i_node_z[W-1], i_node_z};
            r_s1_vel[0] <= i_vel_x;
            r_s1_vel[1] <= i_vel_y;
            r_s1_vel[2] <= i_vel_z;
            r_s1_wall  <= W'(i_sphere_diameter[spcf_pkg::UW-1:1]) + W'(i_node_radius);
        end
    end

    // S2: magnitudes and squares
    always_comb begin
        n_s2_side.vel  = r_s1_vel;
        n_s2_side.wall = r_s1_wall;
        for (int j = 0; j < 3; j++) begin
            n_s2_side.neg[j] = r_s1_d[j][spcf_pkg::DW-1];
            n_s2_side.mag[j] = r_s1_d[j][spcf_pkg::DW-1] ? -r_s1_d[j] : r_s1_d[j];
            n_s2_sq[j] = spcf_pkg::SQW'(n_s2_side.mag[j]) * spcf_pkg::SQW'(n_s2_side.mag[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sq   <= n_s2_sq;
            r_s2_side <= n_s2_side;
            r_s3_sum  <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
            r_s3_side <= r_s2_side;
        end
    end

    spcf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_vld),
        .i_rad   (r_s3_sum),
        .i_side  (r_s3_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // P1: contact test, penetration, divider operands
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_len          <= sq_root[W-1:0];
            r_p1_side.contact <= spcf_pkg::RW'(sq_side.wall) > sq_root;
            r_p1_side.lzero   <= (sq_root == '0);
            r_p1_side.pen     <= sq_side.wall - sq_root[W-1:0];
            r_p1_side.neg     <= sq_side.neg;
            r_p1_side.vel     <= sq_side.vel;
            for (int j = 0; j < 3; j++) begin
                r_p1_num[j] <= {sq_side.mag[j], {spcf_pkg::FRAC{1'b0}}};
            end
        end
    end

    spcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p1_vld),
        .i_div   (r_p1_len),
        .i_num   (r_p1_num),
        .i_side  (r_p1_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // Q1: spring magnitude and damping terms
    always_ff @(posedge i_clk) begin
        logic [W-1:0] vmag;
        if (en) begin
            r_q1_contact <= dv_side.contact;
            r_q1_neg     <= dv_side.neg;
            r_q1_f       <= spcf_pkg::FW'(((2 * W)'(r_stiff) * (2 * W)'(dv_side.pen))
                                          >> spcf_pkg::FRAC);
            for (int j = 0; j < 3; j++) begin
                vmag = dv_side.vel[j][W-1] ? -dv_side.vel[j] : dv_side.vel[j];
                r_q1_vneg[j] <= dv_side.vel[j][W-1];
                r_q1_dm[j]   <= spcf_pkg::FW'(((2 * W)'(vmag) * (2 * W)'(r_damp))
                                              >> spcf_pkg::FRAC);
                // zero length: no spring direction
                r_q1_u[j]    <= dv_side.lzero ? '0 : dv_quo[j];
            end
        end
    end

    // Q2: spring components
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q2_contact <= r_q1_contact;
            r_q2_neg     <= r_q1_neg;
            r_q2_vneg    <= r_q1_vneg;
            r_q2_dm      <= r_q1_dm;
            for (int j = 0; j < 3; j++) begin
                r_q2_sm[j] <= spcf_pkg::SMW'(
                    ((spcf_pkg::FW + spcf_pkg::QW)'(r_q1_f) *
                     (spcf_pkg::FW + spcf_pkg::QW)'(r_q1_u[j])) >> spcf_pkg::FRAC);
            end
        end
    end

    // signed sum and saturation
    always_comb begin
        logic signed [spcf_pkg::SUMW-1:0] spring;
        logic signed [spcf_pkg::SUMW-1:0] damp;
        logic signed [spcf_pkg::SUMW-1:0] sum;
        n_o_sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            spring = r_q2_neg[j]  ? -spcf_pkg::SUMW'(r_q2_sm[j]) : spcf_pkg::SUMW'(r_q2_sm[j]);
            damp   = r_q2_vneg[j] ? -spcf_pkg::SUMW'(r_q2_dm[j]) : spcf_pkg::SUMW'(r_q2_dm[j]);
            sum    = spring + damp;
            if (!r_q2_contact) begin
                n_o_force[j] = '0;
            end else if (sum > spcf_pkg::SAT_HI) begin
                n_o_force[j] = spcf_pkg::F_MAX;
                n_o_sat      = 1'b1;
            end else if (sum < spcf_pkg::SAT_LO) begin
                n_o_force[j] = spcf_pkg::F_MIN;
                n_o_sat      = 1'b1;
            end else begin
                n_o_force[j] = sum[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_contact <= r_q2_contact;
            r_o_force   <= n_o_force;
            r_o_sat     <= n_o_sat;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_in_contact = r_o_contact;
    assign o_force_x    = signed'(r_o_force[0]);
    assign o_force_y    = signed'(r_o_force[1]);
    assign o_force_z    = signed'(r_o_force[2]);
    assign o_saturated  = r_o_sat;

    // no contact gives an all-zero result
    ap_nocontact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_contact |->
            r_o_force[0] == '0 && r_o_force[1] == '0 && r_o_force[2] == '0 && !o_saturated)
        else $error("force without contact");

    // clipping only with contact
    ap_sat_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_in_contact)
        else $error("saturation flagged without contact");

    // a clipped result has a component at a bound
    ap_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            r_o_force[0] == spcf_pkg::F_MAX || r_o_force[0] == spcf_pkg::F_MIN ||
            r_o_force[1] == spcf_pkg::F_MAX || r_o_force[1] == spcf_pkg::F_MIN ||
            r_o_force[2] == spcf_pkg::F_MAX || r_o_force[2] == spcf_pkg::F_MIN)
        else $error("saturation flag without clipped component");

endmodule
